// ===== sv/evm_pkg.sv =====
// Shared types and fixed-point helpers for the Euler Y-X-Z view matrix block.
package evm_pkg;

   localparam int ONE_Q14 = 16384;

   typedef logic signed [15:0] q14_type;
   typedef logic signed [29:0] q28_type;
   typedef logic signed [44:0] q42_type;

   typedef struct packed {
      q14_type m0;
      q14_type m1;
      q14_type m2;
      q14_type m3;
      q14_type m4;
      q14_type m5;
      q14_type m6;
      q14_type m7;
      q14_type m8;
   } mat_type;

   // Clamp a value already at Q14 scale to [-1.0, +1.0].
   function automatic q14_type lim14(input logic signed [31:0] v);
      q14_type res;
      if (v > 32'sd16384) begin
         res = 16'sd16384;
      end else if (v < -32'sd16384) begin
         res = -16'sd16384;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   // Product of two Q14 values rounded back to Q14.
   function automatic q14_type round28(input q28_type v);
      logic signed [30:0] s;
      s = 31'(v) + 31'sd8192;
      return lim14(32'(s >>> 14));
   endfunction

   // Exact Q42 sum rounded to Q14.
   function automatic q14_type round42(input q42_type v);
      logic signed [45:0] s;
      logic signed [45:0] sh;
      s  = 46'(v) + 46'sd134217728;
      sh = s >>> 28;
      return lim14(sh[31:0]);
   endfunction

endpackage

// ===== sv/evm_req_if.sv =====
// Input channel: camera position and three binary angles.
interface evm_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int POS_BITS   = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS-1:0]   pos_x;
   logic signed [POS_BITS-1:0]   pos_y;
   logic signed [POS_BITS-1:0]   pos_z;
   logic        [ANGLE_BITS-1:0] angle_x;
   logic        [ANGLE_BITS-1:0] angle_y;
   logic        [ANGLE_BITS-1:0] angle_z;

   modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                   output ready);
endinterface

// ===== sv/evm_rsp_if.sv =====
// Result channel: rotation rows and translation terms of the view matrix.
interface evm_rsp_if #(
   parameter int POS_BITS = 32
);
   logic                       valid;
   logic                       ready;
   logic signed [15:0]         row0_x;
   logic signed [15:0]         row0_y;
   logic signed [15:0]         row0_z;
   logic signed [15:0]         row1_x;
   logic signed [15:0]         row1_y;
   logic signed [15:0]         row1_z;
   logic signed [15:0]         row2_x;
   logic signed [15:0]         row2_y;
   logic signed [15:0]         row2_z;
   logic signed [POS_BITS+1:0] trans_0;
   logic signed [POS_BITS+1:0] trans_1;
   logic signed [POS_BITS+1:0] trans_2;

   modport source (output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                   row2_x, row2_y, row2_z, trans_0, trans_1, trans_2, input ready);
   modport sink   (input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                   row2_x, row2_y, row2_z, trans_0, trans_1, trans_2, output ready);
endinterface

// ===== sv/euler_yxz_view_matrix.sv =====
// Euler Y-X-Z view matrix pipeline: top level with handshake and stage control.
//
// The req channel carries a camera position (signed Q16.16) and three binary
// angles (yaw, pitch, roll). Each accepted transaction yields one rsp
// transaction holding the nine Q2.14 rotation entries (rows u, v, w) and the
// three Q18.16 translation terms.
//
// Throughput is one transaction per cycle while rsp.ready stays high. The
// accepting edge loads the first of nine register stages: four for the
// polynomial sine (each a dependent multiply), three for the rotation
// products and rounding, two for the translation dot products.
//
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up. When the receiver holds
// rsp.ready low the result stays on rsp, the stages behind fill up, and
// req.ready falls only once all nine are occupied.
//
// Synchronous reset empties all stages; rsp.valid is low after reset.
module euler_yxz_view_matrix
   import evm_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int POS_BITS   = 32
) (
   input logic      clock,
   input logic      reset,
   evm_req_if.sink  req,
   evm_rsp_if.source rsp
);
   localparam int NS = 9;

   logic [NS-1:0] v_ff, v_in, en;
   logic [15:0] ph_x, ph_y, ph_z;
   logic signed [POS_BITS-1:0] px_ff [7];
   logic signed [POS_BITS-1:0] py_ff [7];
   logic signed [POS_BITS-1:0] pz_ff [7];
   q14_type c1, s1, c2, s2, c3, s3;
   mat_type mat, mat_out;
   logic signed [POS_BITS+1:0] trans [3];

   // Bring the angles to a 16-bit phase.
   generate
      if (ANGLE_BITS >= 16) begin : g_phase_wide
         assign ph_x = req.angle_x[ANGLE_BITS-1 -: 16];
         assign ph_y = req.angle_y[ANGLE_BITS-1 -: 16];
         assign ph_z = req.angle_z[ANGLE_BITS-1 -: 16];
      end else begin : g_phase_narrow
         assign ph_x = {req.angle_x, {(16-ANGLE_BITS){1'b0}}};
         assign ph_y = {req.angle_y, {(16-ANGLE_BITS){1'b0}}};
         assign ph_z = {req.angle_z, {(16-ANGLE_BITS){1'b0}}};
      end
   endgenerate

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req.valid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Position rides alongside until the translation stage.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         px_ff[0] <= req.pos_x;
         py_ff[0] <= req.pos_y;
         pz_ff[0] <= req.pos_z;
      end
      for (int i = 1; i < 7; i++) begin
         if (en[i]) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
      end
   end

   evm_sine u_sin_y (.clock(clock), .en(en[3:0]), .phase(ph_y), .y(s1));
   evm_sine u_cos_y (.clock(clock), .en(en[3:0]), .phase(ph_y + 16'd16384), .y(c1));
   evm_sine u_sin_x (.clock(clock), .en(en[3:0]), .phase(ph_x), .y(s2));
   evm_sine u_cos_x (.clock(clock), .en(en[3:0]), .phase(ph_x + 16'd16384), .y(c2));
   evm_sine u_sin_z (.clock(clock), .en(en[3:0]), .phase(ph_z), .y(s3));
   evm_sine u_cos_z (.clock(clock), .en(en[3:0]), .phase(ph_z + 16'd16384), .y(c3));

   evm_rot u_rot (
      .clock(clock), .en(en[6:4]),
      .c1(c1), .s1(s1), .c2(c2), .s2(s2), .c3(c3), .s3(s3),
      .mat(mat)
   );

   evm_trans #(.POS_BITS(POS_BITS)) u_trans (
      .clock(clock), .en(en[8:7]), .mat(mat),
      .pos_x(px_ff[6]), .pos_y(py_ff[6]), .pos_z(pz_ff[6]),
      .mat_out(mat_out), .trans(trans)
   );

   assign req.ready   = en[0];
   assign rsp.valid   = v_ff[NS-1];
   assign rsp.row0_x  = mat_out.m0;
   assign rsp.row0_y  = mat_out.m1;
   assign rsp.row0_z  = mat_out.m2;
   assign rsp.row1_x  = mat_out.m3;
   assign rsp.row1_y  = mat_out.m4;
   assign rsp.row1_z  = mat_out.m5;
   assign rsp.row2_x  = mat_out.m6;
   assign rsp.row2_y  = mat_out.m7;
   assign rsp.row2_z  = mat_out.m8;
   assign rsp.trans_0 = trans[0];
   assign rsp.trans_1 = trans[1];
   assign rsp.trans_2 = trans[2];
endmodule

// ===== sv/evm_sine.sv =====
// Four-stage pipelined polynomial sine of a 16-bit phase.
module evm_sine
   import evm_pkg::*;
(
   input  logic        clock,
   input  logic [3:0]  en,
   input  logic [15:0] phase,
   output q14_type     y
);
   logic [14:0] x_in, x0_ff, x1_ff, x2_ff;
   logic [14:0] sq_in, sq0_ff, sq1_ff;
   logic        n0_ff, n1_ff, n2_ff;
   logic [15:0] t1_in, t1_ff;
   logic [16:0] t2_in, t2_ff;
   logic [29:0] xx;
   logic [27:0] m1;
   logic [30:0] m2;
   logic [31:0] m3;
   logic [15:0] yv;
   q14_type     y_in, y_ff;

   always_comb begin
      // Fold the quadrant so the polynomial only sees the first quarter turn.
      x_in  = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      xx    = 30'(x_in) * 30'(x_in);
      sq_in = 15'((xx + 30'd8192) >> 14);
      m1    = 28'(sq0_ff) * 28'd4639;
      t1_in = 16'(28'd42047 - ((m1 + 28'd8192) >> 14));
      m2    = 31'(t1_ff) * 31'(sq1_ff);
      t2_in = 17'(31'd102944 - ((m2 + 31'd8192) >> 14));
      m3    = 32'(t2_ff) * 32'(x2_ff);
      yv    = 16'((m3 + 32'd32768) >> 16);
      if (yv > 16'd16384) begin
         yv = 16'd16384;
      end
      y_in = n2_ff ? -$signed(yv) : $signed(yv);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff  <= x_in;
         sq0_ff <= sq_in;
         n0_ff  <= phase[15];
      end
      if (en[1]) begin
         x1_ff  <= x0_ff;
         sq1_ff <= sq0_ff;
         n1_ff  <= n0_ff;
         t1_ff  <= t1_in;
      end
      if (en[2]) begin
         x2_ff <= x1_ff;
         n2_ff <= n1_ff;
         t2_ff <= t2_in;
      end
      if (en[3]) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;
endmodule

// ===== sv/evm_rot.sv =====
// Three-stage rotation builder: pair products, triple products, rounded entries.
module evm_rot
   import evm_pkg::*;
(
   input  logic    clock,
   input  logic [2:0] en,
   input  q14_type c1,
   input  q14_type s1,
   input  q14_type c2,
   input  q14_type s2,
   input  q14_type c3,
   input  q14_type s3,
   output mat_type mat
);
   q28_type c1c3_ff, s1s2_ff, c1s2_ff, c3s1_ff, c1s3_ff, s1s3_ff;
   q28_type c2s3_ff, c2c3_ff, c2s1_ff, c1c2_ff;
   q14_type s2_ff, s3_ff;
   q42_type t0_ff, t2_ff, t3_ff, t5_ff;
   q28_type c1c3b_ff, c3s1b_ff, c1s3b_ff, s1s3b_ff;
   q14_type m1_ff, m4_ff, m6_ff, m7_ff, m8_ff;
   mat_type mat_in, mat_ff;

   always_comb begin
      mat_in    = '0;
      mat_in.m0 = round42(45'(c1c3b_ff) * 45'sd16384 + t0_ff);
      mat_in.m1 = m1_ff;
      mat_in.m2 = round42(t2_ff - 45'(c3s1b_ff) * 45'sd16384);
      mat_in.m3 = round42(t3_ff - 45'(c1s3b_ff) * 45'sd16384);
      mat_in.m4 = m4_ff;
      mat_in.m5 = round42(t5_ff + 45'(s1s3b_ff) * 45'sd16384);
      mat_in.m6 = m6_ff;
      mat_in.m7 = m7_ff;
      mat_in.m8 = m8_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c1c3_ff <= q28_type'(c1) * q28_type'(c3);
         s1s2_ff <= q28_type'(s1) * q28_type'(s2);
         c1s2_ff <= q28_type'(c1) * q28_type'(s2);
         c3s1_ff <= q28_type'(c3) * q28_type'(s1);
         c1s3_ff <= q28_type'(c1) * q28_type'(s3);
         s1s3_ff <= q28_type'(s1) * q28_type'(s3);
         c2s3_ff <= q28_type'(c2) * q28_type'(s3);
         c2c3_ff <= q28_type'(c2) * q28_type'(c3);
         c2s1_ff <= q28_type'(c2) * q28_type'(s1);
         c1c2_ff <= q28_type'(c1) * q28_type'(c2);
         s2_ff   <= s2;
         s3_ff   <= s3;
      end
      if (en[1]) begin
         t0_ff    <= 45'(s1s2_ff) * 45'(s3_ff);
         t2_ff    <= 45'(c1s2_ff) * 45'(s3_ff);
         t3_ff    <= 45'(c3s1_ff) * 45'(s2_ff);
         t5_ff    <= 45'(c1c3_ff) * 45'(s2_ff);
         c1c3b_ff <= c1c3_ff;
         c3s1b_ff <= c3s1_ff;
         c1s3b_ff <= c1s3_ff;
         s1s3b_ff <= s1s3_ff;
         m1_ff    <= round28(c2s3_ff);
         m4_ff    <= round28(c2c3_ff);
         m6_ff    <= round28(c2s1_ff);
         m7_ff    <= -s2_ff;
         m8_ff    <= round28(c1c2_ff);
      end
      if (en[2]) begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;
endmodule

// ===== sv/evm_trans.sv =====
// Two-stage translation: row-by-position products, then negated rounded sums.
module evm_trans
   import evm_pkg::*;
#(
   parameter int POS_BITS = 32
) (
   input  logic                       clock,
   input  logic [1:0]                 en,
   input  mat_type                    mat,
   input  logic signed [POS_BITS-1:0] pos_x,
   input  logic signed [POS_BITS-1:0] pos_y,
   input  logic signed [POS_BITS-1:0] pos_z,
   output mat_type                    mat_out,
   output logic signed [POS_BITS+1:0] trans [3]
);
   localparam int PB = POS_BITS + 16;
   localparam int SW = POS_BITS + 19;
   localparam int TB = POS_BITS + 2;
   localparam logic signed [SW-1:0] TMAX = {{(SW-TB+1){1'b0}}, {(TB-1){1'b1}}};
   localparam logic signed [SW-1:0] TMIN = ~TMAX;

   logic signed [PB-1:0] prod_ff [9];
   logic signed [PB-1:0] prod_in [9];
   logic signed [TB-1:0] tr_in [3];
   logic signed [TB-1:0] tr_ff [3];
   logic signed [SW-1:0] sum [3];
   logic signed [SW-1:0] sh [3];
   q14_type              ent [9];
   mat_type              mat_a_ff, mat_b_ff;

   always_comb begin
      ent = '{mat.m0, mat.m1, mat.m2, mat.m3, mat.m4, mat.m5, mat.m6, mat.m7, mat.m8};
      for (int r = 0; r < 3; r++) begin
         prod_in[3*r]   = PB'(ent[3*r])   * PB'(pos_x);
         prod_in[3*r+1] = PB'(ent[3*r+1]) * PB'(pos_y);
         prod_in[3*r+2] = PB'(ent[3*r+2]) * PB'(pos_z);
      end
      for (int r = 0; r < 3; r++) begin
         sum[r] = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2]);
         // Negate with round-half-up, then floor to Q16.
         sh[r]  = (SW'(8192) - sum[r]) >>> 14;
         if (sh[r] > TMAX) begin
            tr_in[r] = TMAX[TB-1:0];
         end else if (sh[r] < TMIN) begin
            tr_in[r] = TMIN[TB-1:0];
         end else begin
            tr_in[r] = sh[r][TB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff  <= prod_in;
         mat_a_ff <= mat;
      end
      if (en[1]) begin
         tr_ff    <= tr_in;
         mat_b_ff <= mat_a_ff;
      end
   end

   assign mat_out = mat_b_ff;
   assign trans   = tr_ff;
endmodule

// ===== sv/evm_checker.sv =====
// Port-level checks for the view matrix pipeline, bound to the top level.
module evm_checker #(
   parameter int POS_BITS = 32
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [15:0]         rsp_row0_x,
   input logic signed [15:0]         rsp_row2_y,
   input logic signed [POS_BITS+1:0] rsp_trans_0
);
   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // With nothing waiting at the output every stage can move.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled while rsp empty");

   // Rotation entries row0_x and row2_y never leave [-1.0, +1.0].
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row0_x <= 16'sd16384) && (rsp_row0_x >= -16'sd16384) &&
      (rsp_row2_y <= 16'sd16384) && (rsp_row2_y >= -16'sd16384))
      else $error("rotation entry out of range");

   // A held result stays valid, and its row0_x and trans_0 do not change.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row0_x) && $stable(rsp_trans_0))
      else $error("rsp changed while stalled");
endmodule

bind euler_yxz_view_matrix evm_checker #(.POS_BITS(POS_BITS)) u_evm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_row0_x(rsp.row0_x), .rsp_row2_y(rsp.row2_y), .rsp_trans_0(rsp.trans_0)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Euler Y-X-Z view matrix pipeline.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import evm_pkg::*;

   localparam int ANGLE_BITS = 16;
   localparam int POS_BITS   = 32;
   localparam int TRANS_BITS = POS_BITS + 2;
   localparam int LATENCY    = 9;
   localparam int N_RANDOM   = 730;

   typedef struct packed {
      logic signed [POS_BITS-1:0] px;
      logic signed [POS_BITS-1:0] py;
      logic signed [POS_BITS-1:0] pz;
      logic [ANGLE_BITS-1:0]      ax;
      logic [ANGLE_BITS-1:0]      ay;
      logic [ANGLE_BITS-1:0]      az;
   } pose_type;

   typedef struct packed {
      mat_type                      m;
      logic signed [TRANS_BITS-1:0] t0;
      logic signed [TRANS_BITS-1:0] t1;
      logic signed [TRANS_BITS-1:0] t2;
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   evm_req_if #(.ANGLE_BITS(ANGLE_BITS), .POS_BITS(POS_BITS)) req();
   evm_rsp_if #(.POS_BITS(POS_BITS)) rsp();

   euler_yxz_view_matrix #(.ANGLE_BITS(ANGLE_BITS), .POS_BITS(POS_BITS)) uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   view_type expected_views[$];
   int       mismatch_count = 0;
   int       view_count     = 0;
   bit       calm           = 1'b0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at view %0d: %s got %0d expected %0d", view_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic longint floor_shift(input longint v, input int k);
      return v >>> k;
   endfunction

   function automatic longint poly_sine(input logic [15:0] p);
      longint r, x, x2, t, y;
      r = p[13:0];
      x = p[14] ? 16384 - r : r;
      x2 = (x * x + 8192) >> 14;
      t = 42047 - ((4639 * x2 + 8192) >> 14);
      t = 102944 - ((t * x2 + 8192) >> 14);
      y = (t * x + 32768) >> 16;
      if (y > 16384) y = 16384;
      return p[15] ? -y : y;
   endfunction

   function automatic longint clamp_one(input longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint from_q42(input longint v);
      return clamp_one(floor_shift(v + (longint'(1) << 27), 28));
   endfunction

   function automatic longint from_q28(input longint v);
      return clamp_one(floor_shift(v + 8192, 14));
   endfunction

   function automatic logic signed [TRANS_BITS-1:0] offset_term(
         input longint ex, input longint ey, input longint ez, input pose_type p);
      longint d, t, hi;
      d = ex * longint'(p.px) + ey * longint'(p.py) + ez * longint'(p.pz);
      t = floor_shift(-d + 8192, 14);
      hi = (longint'(1) <<< (TRANS_BITS - 1)) - 1;
      if (t > hi) t = hi;
      if (t < -hi - 1) t = -hi - 1;
      return t[TRANS_BITS-1:0];
   endfunction

   function automatic view_type view_of(input pose_type p);
      view_type v;
      longint c1, s1, c2, s2, c3, s3;
      longint e[9];
      logic [15:0] phx, phy, phz;
      phx = p.ax << (16 - ANGLE_BITS);
      phy = p.ay << (16 - ANGLE_BITS);
      phz = p.az << (16 - ANGLE_BITS);
      c1 = poly_sine(phy + 16'd16384); s1 = poly_sine(phy);
      c2 = poly_sine(phx + 16'd16384); s2 = poly_sine(phx);
      c3 = poly_sine(phz + 16'd16384); s3 = poly_sine(phz);
      e[0] = from_q42(c1 * c3 * 16384 + s1 * s2 * s3);
      e[1] = from_q28(c2 * s3);
      e[2] = from_q42(c1 * s2 * s3 - c3 * s1 * 16384);
      e[3] = from_q42(c3 * s1 * s2 - c1 * s3 * 16384);
      e[4] = from_q28(c2 * c3);
      e[5] = from_q42(c1 * c3 * s2 + s1 * s3 * 16384);
      e[6] = from_q28(c2 * s1);
      e[7] = -s2;
      e[8] = from_q28(c1 * c2);
      v.m = '{e[0][15:0], e[1][15:0], e[2][15:0], e[3][15:0], e[4][15:0],
              e[5][15:0], e[6][15:0], e[7][15:0], e[8][15:0]};
      v.t0 = offset_term(e[0], e[1], e[2], p);
      v.t1 = offset_term(e[3], e[4], e[5], p);
      v.t2 = offset_term(e[6], e[7], e[8], p);
      return v;
   endfunction

   // Directed rows; the identity pose has a result readable by eye.
   typedef struct {
      pose_type pose;
      bit       typed;
      view_type want;
   } row_type;

   row_type directed[$];

   function automatic pose_type make_pose(input longint x, input longint y, input longint z,
                                          input int ax, input int ay, input int az);
      pose_type p;
      p.px = x[POS_BITS-1:0]; p.py = y[POS_BITS-1:0]; p.pz = z[POS_BITS-1:0];
      p.ax = ax[ANGLE_BITS-1:0]; p.ay = ay[ANGLE_BITS-1:0]; p.az = az[ANGLE_BITS-1:0];
      return p;
   endfunction

   function automatic void add_row(input pose_type p);
      row_type r;
      r.pose = p; r.typed = 1'b0; r.want = '0;
      directed.push_back(r);
   endfunction

   function automatic void build_directed();
      row_type r;
      longint mx, mn;
      mx = 64'sd2147483647;
      mn = -64'sd2147483648;
      // Identity rotation, translation is simply -position.
      r.pose = make_pose(65536, -131072, 0, 0, 0, 0);
      r.typed = 1'b1;
      r.want.m = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                   16'sd0, 16'sd0, 16'sd16384};
      r.want.t0 = -34'sd65536; r.want.t1 = 34'sd131072; r.want.t2 = 34'sd0;
      directed.push_back(r);
      r.pose = make_pose(0, 0, 0, 0, 0, 0);
      r.want.t1 = 34'sd0; r.want.t0 = 34'sd0;
      directed.push_back(r);
      // Quarter, half and three-quarter turns on each axis give exact plus and minus one; mixed angles follow.
      add_row(make_pose(mx, mx, mx, 16384, 0, 0));
      add_row(make_pose(mn, mn, mn, 32768, 0, 0));
      add_row(make_pose(mx, mn, mx, 49152, 0, 0));
      add_row(make_pose(mn, mx, mn, 0, 16384, 0));
      add_row(make_pose(mx, mx, mn, 0, 32768, 0));
      add_row(make_pose(mn, mn, mx, 0, 49152, 0));
      add_row(make_pose(-1, -1, -1, 0, 0, 16384));
      add_row(make_pose(1, 1, 1, 0, 0, 32768));
      add_row(make_pose(mx, 0, mn, 0, 0, 49152));
      add_row(make_pose(mx, mx, mx, 65535, 65535, 65535));
      add_row(make_pose(mn, mn, mn, 1, 1, 1));
      add_row(make_pose(mx, mx, mx, 8192, 8192, 8192));
      add_row(make_pose(mn, mn, mn, 8192, 57344, 24576));
      add_row(make_pose(mx, mn, mx, 16383, 16385, 32767));
      add_row(make_pose(12345678, -87654321, 5555, 43690, 21845, 4660));
      add_row(make_pose(0, mx, 0, 16384, 16384, 16384));
      add_row(make_pose(mn, 0, mx, 49152, 49152, 49152));
   endfunction

   pose_type pose_queue[$];
   bit       all_sent = 1'b0;

   // Sender: drives at the falling edge, pops the front after acceptance.
   initial begin
      pose_type p;
      int i;
      bit held;
      req.valid = 1'b0;
      {req.pos_x, req.pos_y, req.pos_z, req.angle_x, req.angle_y, req.angle_z} = '0;
      build_directed();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (i = 0; i < directed.size(); i++) pose_queue.push_back(directed[i].pose);
      for (i = 0; i < N_RANDOM; i++) begin
         p = make_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         case ($urandom_range(0, 5))
            0: p.ax = 16'(16384 * $urandom_range(0, 3));
            1: p.py = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: begin
               p.px = $signed(32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000));
               p.pz = p.px;
            end
            default: ;
         endcase
         pose_queue.push_back(p);
      end
      i = 0;
      held = 1'b0;
      while (pose_queue.size() > 0) begin
         // Hold off once mid-run until the pipeline drains completely.
         if (i == 300 && !held) begin
            req.valid <= 1'b0;
            while (expected_views.size() > 0) @(negedge clock);
         end
         // A transaction once offered stays offered until it is taken.
         if (calm || held || $urandom_range(0, 99) >= 32) begin
            p = pose_queue[0];
            req.valid <= 1'b1;
            req.pos_x <= p.px; req.pos_y <= p.py; req.pos_z <= p.pz;
            req.angle_x <= p.ax; req.angle_y <= p.ay; req.angle_z <= p.az;
            @(posedge clock);
            held = !req.ready;
            if (req.ready) begin
               expected_views.push_back(view_of(p));
               void'(pose_queue.pop_front());
               i++;
            end
         end else begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
         @(negedge clock);
      end
      req.valid <= 1'b0;
      all_sent = 1'b1;
   end

   // A stretch without idling on either side.
   initial begin
      wait (reset == 1'b0);
      repeat (400) @(posedge clock);
      calm = 1'b1;
      repeat (300) @(posedge clock);
      calm = 1'b0;
   end

   // Receiver: random stalls, checks every accepted result.
   initial begin
      view_type w, g;
      int idx;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 32);
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            g.m = '{rsp.row0_x, rsp.row0_y, rsp.row0_z, rsp.row1_x, rsp.row1_y,
                    rsp.row1_z, rsp.row2_x, rsp.row2_y, rsp.row2_z};
            g.t0 = rsp.trans_0; g.t1 = rsp.trans_1; g.t2 = rsp.trans_2;
            if (expected_views.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               w = expected_views.pop_front();
               // The first two directed rows carry hand-written results.
               if (view_count < 2) begin
                  idx = view_count;
                  if (directed[idx].typed) w = directed[idx].want;
               end
               if (g.m.m0 != w.m.m0) report("row0_x", g.m.m0, w.m.m0);
               if (g.m.m1 != w.m.m1) report("row0_y", g.m.m1, w.m.m1);
               if (g.m.m2 != w.m.m2) report("row0_z", g.m.m2, w.m.m2);
               if (g.m.m3 != w.m.m3) report("row1_x", g.m.m3, w.m.m3);
               if (g.m.m4 != w.m.m4) report("row1_y", g.m.m4, w.m.m4);
               if (g.m.m5 != w.m.m5) report("row1_z", g.m.m5, w.m.m5);
               if (g.m.m6 != w.m.m6) report("row2_x", g.m.m6, w.m.m6);
               if (g.m.m7 != w.m.m7) report("row2_y", g.m.m7, w.m.m7);
               if (g.m.m8 != w.m.m8) report("row2_z", g.m.m8, w.m.m8);
               if (g.t0 != w.t0) report("trans_0", g.t0, w.t0);
               if (g.t1 != w.t1) report("trans_1", g.t1, w.t1);
               if (g.t2 != w.t2) report("trans_2", g.t2, w.t2);
            end
            view_count++;
         end
      end
   end

   initial begin
      wait (all_sent);
      while (expected_views.size() > 0) @(posedge clock);
      repeat (LATENCY * 4) @(posedge clock);
      $display("Checked %0d view matrices: %0d directed poses, %0d random poses.",
               view_count, directed.size(), N_RANDOM);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
